// ----- sv/wac_pkg.sv -----
// Shared types and constants for the weighted automaton builder.
`default_nettype none
package wac_pkg;
	localparam int NODE_W    = 10;
	localparam int LET_W     = 5;
	localparam int VAL_W     = 16;
	localparam int SCORE_W   = 24;
	localparam int KIND_W    = 3;
	localparam int STAT_W    = 2;
	localparam int ALPHA     = 26;
	localparam int MAX_NODES = 1024;
	localparam int CNT_W     = NODE_W + 1;
	localparam int GADDR_W   = NODE_W + LET_W;

	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
	localparam logic [STAT_W-1:0] ST_BAD  = 2'd2;

	typedef enum logic [KIND_W-1:0] {
		KIND_CLEAR  = 3'd0,
		KIND_LETTER = 3'd1,
		KIND_END    = 3'd2,
		KIND_BUILD  = 3'd3,
		KIND_STEP   = 3'd4
	} kind_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LATCH, OP_CLEAR, OP_SWEEP, OP_LET_RD, OP_LET_ADV, OP_ALLOC,
		OP_END, OP_STEP_RD, OP_STEP_SC, OP_B_START, OP_B_POP, OP_B_FL, OP_B_RD,
		OP_B_SON, OP_B_SCORE
	} dp_op_t;

	typedef enum logic [3:0] {
		S_RST, S_IDLE, S_DISP, S_LET_CHK, S_SWEEP, S_STEP_SC, S_B_POP, S_B_FL,
		S_B_RD, S_B_CHK, S_B_SCORE, S_B_FILL, S_DONE
	} state_t;

	typedef struct packed {
		dp_op_t            op;
		logic              fill;
		logic              finish;
		logic              res_load;
		logic [STAT_W-1:0] res_status;
	} cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              letter_ok;
		logic              from_ok;
		logic              built;
		logic              g_nz;
		logic              full;
		logic              sweep_last;
		logic              col_last;
		logic              q_empty;
		logic              out_free;
	} stat_t;
endpackage
`default_nettype wire

// ----- sv/wac_ctrl.sv -----
// Sequencer for item handling, row clearing and the breadth-first build.
`default_nettype none
module wac_ctrl import wac_pkg::*; (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          in_valid,
	output logic         in_stall,
	input  wire stat_t   st,
	output cmd_t         cmd
);
	state_t            state_q, state_d;
	logic [STAT_W-1:0] status_q, status_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_RST;
			status_q <= ST_OK;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		status_d = status_q;
		case (state_q)
			S_RST: if (st.sweep_last) state_d = S_IDLE;
			S_IDLE: if (in_valid) state_d = S_DISP;
			S_DISP: begin
				state_d  = S_DONE;
				status_d = ST_OK;
				case (st.kind)
					KIND_CLEAR: state_d = S_SWEEP;
					KIND_LETTER: begin
						if (st.built || !st.letter_ok) status_d = ST_BAD;
						else state_d = S_LET_CHK;
					end
					KIND_END: if (st.built) status_d = ST_BAD;
					KIND_BUILD: begin
						if (st.built) status_d = ST_BAD;
						else state_d = S_B_POP;
					end
					KIND_STEP: begin
						if (!st.built || !st.letter_ok || !st.from_ok) status_d = ST_BAD;
						else state_d = S_STEP_SC;
					end
					default: status_d = ST_BAD;
				endcase
			end
			S_LET_CHK: begin
				if (st.g_nz) state_d = S_DONE;
				else if (st.full) begin
					status_d = ST_FULL;
					state_d  = S_DONE;
				end else state_d = S_SWEEP;
			end
			S_SWEEP: if (st.sweep_last) state_d = S_DONE;
			S_STEP_SC: state_d = S_DONE;
			S_B_POP: state_d = st.q_empty ? S_DONE : S_B_FL;
			S_B_FL: state_d = S_B_RD;
			S_B_RD: state_d = S_B_CHK;
			S_B_CHK: begin
				if (st.g_nz) state_d = S_B_SCORE;
				else state_d = S_B_FILL;
			end
			S_B_SCORE, S_B_FILL: state_d = st.col_last ? S_B_POP : S_B_RD;
			S_DONE: if (st.out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd            = '0;
		cmd.op         = OP_NONE;
		cmd.res_status = status_q;
		in_stall       = (state_q != S_IDLE);
		case (state_q)
			S_RST: cmd.op = OP_SWEEP;
			S_IDLE: if (in_valid) cmd.op = OP_LATCH;
			S_DISP: begin
				case (st.kind)
					KIND_CLEAR: cmd.op = OP_CLEAR;
					KIND_LETTER: if (!st.built && st.letter_ok) cmd.op = OP_LET_RD;
					KIND_END: if (!st.built) cmd.op = OP_END;
					KIND_BUILD: if (!st.built) cmd.op = OP_B_START;
					KIND_STEP: begin
						if (st.built && st.letter_ok && st.from_ok) cmd.op = OP_STEP_RD;
					end
					default: cmd.op = OP_NONE;
				endcase
			end
			S_LET_CHK: begin
				if (st.g_nz) cmd.op = OP_LET_ADV;
				else if (!st.full) cmd.op = OP_ALLOC;
			end
			S_SWEEP: cmd.op = OP_SWEEP;
			S_STEP_SC: cmd.op = OP_STEP_SC;
			S_B_POP: begin
				if (st.q_empty) cmd.finish = 1'b1;
				else cmd.op = OP_B_POP;
			end
			S_B_FL: cmd.op = OP_B_FL;
			S_B_RD: cmd.op = OP_B_RD;
			S_B_CHK: if (st.g_nz) cmd.op = OP_B_SON;
			S_B_SCORE: cmd.op = OP_B_SCORE;
			S_B_FILL: cmd.fill = 1'b1;
			S_DONE: cmd.res_load = st.out_free;
			default: cmd.op = OP_NONE;
		endcase
	end
endmodule
`default_nettype wire

// ----- sv/wac_dp.sv -----
// Datapath: trie memories, build queue, cursors and the result register.
`default_nettype none
module wac_dp import wac_pkg::*; (
	input  wire                clk,
	input  wire                arst_n,
	input  wire cmd_t          cmd,
	output stat_t              st,
	input  wire [KIND_W-1:0]   kind,
	input  wire [LET_W-1:0]    letter,
	input  wire [VAL_W-1:0]    pattern_value,
	input  wire [NODE_W-1:0]   from_node,
	output logic               out_valid,
	input  wire                out_stall,
	output logic [STAT_W-1:0]  status,
	output logic [NODE_W-1:0]  next_node,
	output logic [SCORE_W-1:0] score
);
	logic [NODE_W-1:0]  goto_mem [2**GADDR_W];
	logic [NODE_W-1:0]  fl_mem   [MAX_NODES];
	logic [SCORE_W-1:0] sc_mem   [MAX_NODES];
	logic [NODE_W-1:0]  q_mem    [MAX_NODES];

	logic [KIND_W-1:0]  kind_q;
	logic [LET_W-1:0]   letter_q;
	logic [VAL_W-1:0]   value_q;
	logic [NODE_W-1:0]  from_q;
	logic [NODE_W-1:0]  count_q, cursor_q, row_q, p_q;
	logic [LET_W-1:0]   col_q;
	logic               built_q;
	logic [CNT_W-1:0]   head_q, tail_q;
	logic [NODE_W-1:0]  ga_q, gb_q, fl_q, qr_q;
	logic [SCORE_W-1:0] sa_q, sb_q;
	logic [NODE_W-1:0]  fp, f;
	logic [SCORE_W:0]   sum;

	logic               g_we;
	logic [GADDR_W-1:0] g_waddr, g_ra, g_rb;
	logic [NODE_W-1:0]  g_wdata;
	logic               s_we;
	logic [NODE_W-1:0]  s_waddr, s_ra;
	logic [SCORE_W-1:0] s_wdata;
	logic               out_free;

	assign fp       = (p_q == '0) ? '0 : fl_q;
	assign f        = (p_q == '0) ? '0 : gb_q;
	assign sum      = {1'b0, sa_q} + {1'b0, sb_q};
	assign out_free = !out_valid || !out_stall;

	always_comb begin
		g_we    = 1'b0;
		g_waddr = {row_q, col_q};
		g_wdata = '0;
		g_ra    = {p_q, col_q};
		g_rb    = {fp, col_q};
		s_we    = 1'b0;
		s_waddr = row_q;
		s_wdata = '0;
		s_ra    = ga_q;
		case (cmd.op)
			OP_SWEEP: begin
				g_we = 1'b1;
				s_we = 1'b1;
			end
			OP_LET_RD: g_ra = {cursor_q, letter_q};
			OP_STEP_RD: g_ra = {from_q, letter_q};
			OP_ALLOC: begin
				g_we    = 1'b1;
				g_waddr = {cursor_q, letter_q};
				g_wdata = count_q + 1'b1;
			end
			OP_END: begin
				s_we    = 1'b1;
				s_waddr = cursor_q;
				s_wdata = SCORE_W'(value_q);
			end
			OP_B_SON: s_ra = ga_q;
			OP_B_SCORE: begin
				s_we    = 1'b1;
				s_waddr = ga_q;
				s_wdata = sum[SCORE_W] ? '1 : sum[SCORE_W-1:0];
			end
			default: g_we = 1'b0;
		endcase
		if (cmd.fill) begin
			g_we    = 1'b1;
			g_waddr = {p_q, col_q};
			g_wdata = f;
		end
	end

	// ga_q holds the looked-up entry until the next lookup
	always_ff @(posedge clk) begin
		if (g_we) goto_mem[g_waddr] <= g_wdata;
		if (cmd.op == OP_LET_RD || cmd.op == OP_STEP_RD || cmd.op == OP_B_RD)
			ga_q <= goto_mem[g_ra];
		if (cmd.op == OP_B_RD) gb_q <= goto_mem[g_rb];
	end

	always_ff @(posedge clk) begin
		if (s_we) sc_mem[s_waddr] <= s_wdata;
		if (cmd.op == OP_STEP_SC || cmd.op == OP_B_SON) sa_q <= sc_mem[s_ra];
		if (cmd.op == OP_B_SON) sb_q <= sc_mem[f];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_B_SON) fl_mem[ga_q] <= f;
		if (cmd.op == OP_B_FL) fl_q <= fl_mem[qr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_B_START) q_mem[0] <= '0;
		else if (cmd.op == OP_B_SON && tail_q < CNT_W'(MAX_NODES))
			q_mem[tail_q[NODE_W-1:0]] <= ga_q;
		if (cmd.op == OP_B_POP) qr_q <= q_mem[head_q[NODE_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LATCH) begin
			kind_q   <= kind;
			letter_q <= letter;
			value_q  <= pattern_value;
			from_q   <= from_node;
		end
		if (cmd.op == OP_B_FL) p_q <= qr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			cursor_q <= '0;
			row_q    <= '0;
			col_q    <= '0;
			built_q  <= 1'b0;
			head_q   <= '0;
			tail_q   <= '0;
		end else begin
			case (cmd.op)
				OP_CLEAR: begin
					count_q  <= '0;
					cursor_q <= '0;
					row_q    <= '0;
					col_q    <= '0;
					built_q  <= 1'b0;
				end
				OP_SWEEP: col_q <= st.sweep_last ? '0 : col_q + 1'b1;
				OP_LET_ADV: cursor_q <= ga_q;
				OP_ALLOC: begin
					count_q  <= count_q + 1'b1;
					cursor_q <= count_q + 1'b1;
					row_q    <= count_q + 1'b1;
					col_q    <= '0;
				end
				OP_END: cursor_q <= '0;
				OP_B_START: begin
					head_q <= '0;
					tail_q <= CNT_W'(1);
				end
				OP_B_POP: head_q <= head_q + 1'b1;
				OP_B_FL: col_q <= '0;
				OP_B_SON: if (tail_q < CNT_W'(MAX_NODES)) tail_q <= tail_q + 1'b1;
				OP_B_SCORE: col_q <= col_q + 1'b1;
				default: ;
			endcase
			if (cmd.fill) col_q <= col_q + 1'b1;
			if (cmd.finish) begin
				built_q  <= 1'b1;
				cursor_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.res_load) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status <= cmd.res_status;
			if (cmd.res_status == ST_OK && kind_q == KIND_STEP) begin
				next_node <= ga_q;
				score     <= sa_q;
			end else begin
				next_node <= '0;
				score     <= '0;
			end
		end
	end

	always_comb begin
		st.kind       = kind_q;
		st.letter_ok  = letter_q < LET_W'(ALPHA);
		st.from_ok    = from_q <= count_q;
		st.built      = built_q;
		st.g_nz       = ga_q != '0;
		st.full       = count_q == NODE_W'(MAX_NODES - 1);
		st.sweep_last = col_q == LET_W'(ALPHA - 1);
		st.col_last   = col_q == LET_W'(ALPHA - 1);
		st.q_empty    = head_q == tail_q;
		st.out_free   = out_free;
	end
endmodule
`default_nettype wire

// ----- sv/weighted_aho_corasick_builder.sv -----
// Top level of the weighted automaton builder.
// One result per input transfer, one item in flight at a time. After reset the root row is
// cleared before the first input is taken. A clear resets the trie and zeroes its root row.
// A letter that allocates a node also zeroes that node's goto row. Build walks the trie breadth
// first through the goto table's two read ports, one node at a time and each letter of its row
// in turn. A stalled result holds the item until the result is taken.
`default_nettype none
module weighted_aho_corasick_builder import wac_pkg::*; (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire [KIND_W-1:0]   kind,
	input  wire [LET_W-1:0]    letter,
	input  wire [VAL_W-1:0]    pattern_value,
	input  wire [NODE_W-1:0]   from_node,
	output logic               out_valid,
	input  wire                out_stall,
	output logic [STAT_W-1:0]  status,
	output logic [NODE_W-1:0]  next_node,
	output logic [SCORE_W-1:0] score
);
	cmd_t  cmd;
	stat_t st;

	wac_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	wac_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.kind          (kind),
		.letter        (letter),
		.pattern_value (pattern_value),
		.from_node     (from_node),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.next_node     (next_node),
		.score         (score)
	);
endmodule
`default_nettype wire
